### rtl/core/vri_pkg.sv
// Package for the velocity rollout integrator: field widths, fixed-point
// constants, register indexes and small arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps

package vri_pkg;

  // Field widths
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned POSE_W  = 32;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned HEAD0_W = 19;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // CORDIC iteration count default and the arctangent table length
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_LEN         = 24;

  // Register reset values
  localparam logic [STEP_W-1:0] STEP_TIME_RST = 16'd6554;

  // Angle constants, Q2.30
  localparam logic signed [34:0] GAIN_Q30    = 35'sd652032874;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;

  // Modulo reduction: |heading| * 2^14 fits 46 bits; 13 shifted subtracts
  localparam int unsigned REM_W   = 46;
  localparam logic [REM_W-1:0] TWO_PI_REM = 46'd6746518852;
  localparam logic [3:0] RED_TOP = 4'd12;

  // Datapath widths
  localparam int unsigned CS_W   = 34;  // cosine / sine, Q2.30 with headroom
  localparam int unsigned Z_W    = 35;  // angle residue, Q2.30
  localparam int unsigned PROD_W = 51;  // 17 x 34 signed product
  localparam int unsigned DV_W   = 50;  // world-frame velocity, Q.42
  localparam int unsigned LO_W   = 25;  // low split of the velocity for the dt product
  localparam int unsigned PLO_W  = 41;  // dt times the low split
  localparam int unsigned INC_W  = 26;  // position increment, Q10.16

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_TIME     = 3'd0,
    REG_START_X       = 3'd1,
    REG_START_Y       = 3'd2,
    REG_START_HEADING = 3'd3,
    REG_HOLONOMIC     = 3'd4
  } cfg_reg_e;

  // Saturate to the signed 32 bit range
  function automatic logic signed [POSE_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [POSE_W-1:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[POSE_W-1:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[POSE_W-1:0];
    end else begin
      r = v[POSE_W-1:0];
    end
    return r;
  endfunction

  // Round half up of (hi * 2^25 + lo) / 2^42
  function automatic logic signed [INC_W-1:0] round_q42(input logic signed [PROD_W-1:0] hi,
                                                         input logic [PLO_W-1:0] lo);
    logic signed [67:0] s;
    s = ({{17{hi[PROD_W-1]}}, hi} <<< LO_W) + {27'd0, lo} + (68'sd1 <<< 41);
    return s[67:42];
  endfunction

  // Truncated arctangent of 2^-i, Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:  a = 32'd843314856;
      5'd1:  a = 32'd497837829;
      5'd2:  a = 32'd263043836;
      5'd3:  a = 32'd133525158;
      5'd4:  a = 32'd67021686;
      5'd5:  a = 32'd33543515;
      5'd6:  a = 32'd16775850;
      5'd7:  a = 32'd8388437;
      5'd8:  a = 32'd4194282;
      5'd9:  a = 32'd2097149;
      5'd10: a = 32'd1048575;
      5'd11: a = 32'd524287;
      5'd12: a = 32'd262143;
      5'd13: a = 32'd131071;
      5'd14: a = 32'd65535;
      5'd15: a = 32'd32767;
      5'd16: a = 32'd16383;
      5'd17: a = 32'd8191;
      5'd18: a = 32'd4095;
      5'd19: a = 32'd2047;
      5'd20: a = 32'd1023;
      5'd21: a = 32'd511;
      5'd22: a = 32'd255;
      5'd23: a = 32'd127;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

### rtl/core/vri_ifs.sv
// Channel interfaces of the velocity rollout integrator: step request,
// pose result and register write. Depends on vri_pkg.
`timescale 1ns / 1ps

interface vri_req_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vri_pkg::SPEED_W-1:0]   forward_speed;
  logic signed [vri_pkg::SPEED_W-1:0]   lateral_speed;
  logic signed [vri_pkg::SPEED_W-1:0]   turn_rate;
  logic                                 rollout_start;

  modport source(output valid, forward_speed, lateral_speed, turn_rate, rollout_start,
                 input ready);
  modport sink(input valid, forward_speed, lateral_speed, turn_rate, rollout_start,
               output ready);
endinterface

interface vri_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [vri_pkg::POSE_W-1:0]   pose_x;
  logic signed [vri_pkg::POSE_W-1:0]   pose_y;
  logic signed [vri_pkg::POSE_W-1:0]   pose_heading;

  modport source(output valid, pose_x, pose_y, pose_heading, input ready);
  modport sink(input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface vri_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [vri_pkg::CFG_IDX_W-1:0]      index;
  logic [vri_pkg::CFG_DATA_W-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/velocity_rollout_integrator.sv
// Velocity rollout integrator top level: heading/position dead reckoning
// with a shared multiplier, an iterative modulo reduction and a CORDIC.
// Depends on vri_pkg and the interfaces in vri_ifs.sv.
//
//  channel  dir  modport  payload                                      moves
//  req_i    in   sink     forward_speed, lateral_speed, turn_rate,      one step request
//                         rollout_start
//  res_o    out  source   pose_x, pose_y, pose_heading                 one pose per request
//  cfg_i    in   sink     index, data                                  one register write
//
// A request is taken only in the idle state, so a new request waits until
// the previous pose has been handed to the output register. Each step runs
// the 13-step modulo-2pi reduction, the CORDIC iterations and nine passes
// through the single 17x34 multiplier.
// rst_ni clears the pose accumulators and loads register reset values.
// A finished pose waits in the output register; the last step holds off
// until that register is free. Register writes are always taken.
`timescale 1ns / 1ps

module velocity_rollout_integrator #(
  parameter int unsigned CORDIC_STEPS = vri_pkg::CORDIC_STEPS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  vri_req_if.sink   req_i,
  vri_res_if.source res_o,
  vri_cfg_if.sink   cfg_i
);

  localparam int unsigned IW = $clog2(CORDIC_STEPS);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_HMUL  = 19'h00002,
    S_HADD  = 19'h00004,
    S_RINIT = 19'h00008,
    S_RED   = 19'h00010,
    S_WRAP  = 19'h00020,
    S_FOLD  = 19'h00040,
    S_CORD  = 19'h00080,
    S_CNEG  = 19'h00100,
    S_MVC   = 19'h00200,
    S_MVS   = 19'h00400,
    S_MWS   = 19'h00800,
    S_MWC   = 19'h01000,
    S_XLO   = 19'h02000,
    S_XHI   = 19'h04000,
    S_YLO   = 19'h08000,
    S_YHI   = 19'h10000,
    S_YSUM  = 19'h20000,
    S_DONE  = 19'h40000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [vri_pkg::STEP_W-1:0]          step_time_q;
  logic signed [vri_pkg::POSE_W-1:0]   start_x_q, start_y_q;
  logic signed [vri_pkg::HEAD0_W-1:0]  start_heading_q;
  logic                                holonomic_q;

  // Pose accumulators and output register
  logic signed [vri_pkg::POSE_W-1:0]   head_q, x_acc_q, y_acc_q;
  logic signed [vri_pkg::POSE_W-1:0]   out_x_q, out_y_q, out_head_q;
  logic                                out_valid_q;

  // Datapath registers
  logic signed [vri_pkg::SPEED_W-1:0]  v_q, w_q, r_q;
  logic [vri_pkg::REM_W-1:0]           rem_q;
  logic                                zneg_q, fneg_q;
  logic [3:0]                          k_q;
  logic [IW-1:0]                       iter_q;
  logic signed [vri_pkg::Z_W-1:0]      z_q;
  logic signed [vri_pkg::CS_W-1:0]     cx_q, cy_q;
  logic signed [vri_pkg::DV_W-1:0]     dx_q, dy_q;
  logic signed [vri_pkg::PROD_W-1:0]   prod_q;
  logic [vri_pkg::PLO_W-1:0]           plo_q;
  logic signed [vri_pkg::INC_W-1:0]    inc_q;

  // Shared multiplier operands
  logic signed [16:0]                  mul_a;
  logic signed [vri_pkg::CS_W-1:0]     mul_b;
  logic signed [vri_pkg::PROD_W-1:0]   prod_d;

  // Combinational helpers
  logic                                req_fire, res_free;
  logic signed [vri_pkg::PROD_W-1:0]   head_rnd;
  logic signed [vri_pkg::POSE_W-1:0]   head_new, x_new, y_new;
  logic [vri_pkg::POSE_W-1:0]          head_mag;
  logic [vri_pkg::REM_W:0]             red_diff;
  logic signed [vri_pkg::Z_W-1:0]      z_signed, z_wrap;
  logic signed [vri_pkg::CS_W-1:0]     xs, ys;
  logic signed [vri_pkg::Z_W-1:0]      atan_z;

  assign req_fire = req_i.valid && req_i.ready;
  assign res_free = !out_valid_q || res_o.ready;

  assign req_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign res_o.valid  = out_valid_q;
  assign res_o.pose_x       = out_x_q;
  assign res_o.pose_y       = out_y_q;
  assign res_o.pose_heading = out_head_q;

  // Heading update: round(r*dt / 2^12) added with saturation
  assign head_rnd = (prod_q + 51'sd2048) >>> 12;
  assign head_new = vri_pkg::sat32({{32{head_q[31]}}, head_q} + {{13{head_rnd[50]}}, head_rnd});

  // Position updates
  assign x_new = vri_pkg::sat32({{32{x_acc_q[31]}}, x_acc_q} + {{38{inc_q[25]}}, inc_q});
  assign y_new = vri_pkg::sat32({{32{y_acc_q[31]}}, y_acc_q} + {{38{inc_q[25]}}, inc_q});

  // Modulo reduction: one shifted 2pi compare-subtract per cycle
  assign head_mag = head_q[31] ? 32'(-head_q) : 32'(head_q);
  assign red_diff = {1'b0, rem_q} - {1'b0, (vri_pkg::TWO_PI_REM << k_q)};

  // Restore the dividend's sign, then wrap into [-pi, pi]
  always_comb begin
    z_signed = zneg_q ? -$signed({1'b0, rem_q[33:0]}) : $signed({1'b0, rem_q[33:0]});
    if (z_signed > vri_pkg::PI_Q30) begin
      z_wrap = z_signed - vri_pkg::TWO_PI_Q30;
    end else if (z_signed < -vri_pkg::PI_Q30) begin
      z_wrap = z_signed + vri_pkg::TWO_PI_Q30;
    end else begin
      z_wrap = z_signed;
    end
  end

  // CORDIC micro-rotation terms
  assign xs     = cx_q >>> iter_q;
  assign ys     = cy_q >>> iter_q;
  assign atan_z = $signed({3'b000, vri_pkg::atan_q30(5'(iter_q))});

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_HMUL: begin
        mul_a = {r_q[15], r_q};
        mul_b = $signed({18'd0, step_time_q});
      end
      S_MVC: begin
        mul_a = {v_q[15], v_q};
        mul_b = cx_q;
      end
      S_MVS: begin
        mul_a = {v_q[15], v_q};
        mul_b = cy_q;
      end
      S_MWS: begin
        mul_a = {w_q[15], w_q};
        mul_b = cy_q;
      end
      S_MWC: begin
        mul_a = {w_q[15], w_q};
        mul_b = cx_q;
      end
      S_XLO: begin
        mul_a = $signed({1'b0, step_time_q});
        mul_b = $signed({9'd0, dx_q[24:0]});
      end
      S_XHI: begin
        mul_a = $signed({1'b0, step_time_q});
        mul_b = {{9{dx_q[49]}}, dx_q[49:25]};
      end
      S_YLO: begin
        mul_a = $signed({1'b0, step_time_q});
        mul_b = $signed({9'd0, dy_q[24:0]});
      end
      S_YHI: begin
        mul_a = $signed({1'b0, step_time_q});
        mul_b = {{9{dy_q[49]}}, dy_q[49:25]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (req_fire) state_d = S_HMUL;
      S_HMUL:  state_d = S_HADD;
      S_HADD:  state_d = S_RINIT;
      S_RINIT: state_d = S_RED;
      S_RED:   if (k_q == 4'd0) state_d = S_WRAP;
      S_WRAP:  state_d = S_FOLD;
      S_FOLD:  state_d = S_CORD;
      S_CORD:  if (iter_q == IW'(CORDIC_STEPS - 1)) state_d = S_CNEG;
      S_CNEG:  state_d = S_MVC;
      S_MVC:   state_d = S_MVS;
      S_MVS:   state_d = S_MWS;
      S_MWS:   state_d = S_MWC;
      S_MWC:   state_d = S_XLO;
      S_XLO:   state_d = S_XHI;
      S_XHI:   state_d = S_YLO;
      S_YLO:   state_d = S_YHI;
      S_YHI:   state_d = S_YSUM;
      S_YSUM:  state_d = S_DONE;
      S_DONE:  if (res_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control, configuration and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      step_time_q     <= vri_pkg::STEP_TIME_RST;
      start_x_q       <= '0;
      start_y_q       <= '0;
      start_heading_q <= '0;
      holonomic_q     <= 1'b0;
      head_q          <= '0;
      x_acc_q         <= '0;
      y_acc_q         <= '0;
      out_valid_q     <= 1'b0;
      k_q             <= '0;
      iter_q          <= '0;
    end else begin
      state_q <= state_d;

      // Register writes
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          vri_pkg::REG_STEP_TIME:     step_time_q     <= cfg_i.data[15:0];
          vri_pkg::REG_START_X:       start_x_q       <= $signed(cfg_i.data);
          vri_pkg::REG_START_Y:       start_y_q       <= $signed(cfg_i.data);
          vri_pkg::REG_START_HEADING: start_heading_q <= $signed(cfg_i.data[18:0]);
          vri_pkg::REG_HOLONOMIC:     holonomic_q     <= cfg_i.data[0];
          default: ;
        endcase
      end

      // Output valid: set when a pose is loaded, cleared once taken
      if ((state_q == S_DONE) && res_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_fire && req_i.rollout_start) begin
            head_q  <= {{13{start_heading_q[18]}}, start_heading_q};
            x_acc_q <= start_x_q;
            y_acc_q <= start_y_q;
          end
        end
        S_HADD:  head_q <= head_new;
        S_RINIT: k_q <= vri_pkg::RED_TOP;
        S_RED:   k_q <= k_q - 4'd1;
        S_FOLD:  iter_q <= '0;
        S_CORD:  iter_q <= iter_q + IW'(1);
        S_YHI:   x_acc_q <= x_new;
        S_DONE: begin
          if (res_free) begin
            y_acc_q <= y_new;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          v_q <= req_i.forward_speed;
          w_q <= holonomic_q ? req_i.lateral_speed : '0;
          r_q <= req_i.turn_rate;
        end
      end
      S_RINIT: begin
        rem_q  <= {head_mag, 14'd0};
        zneg_q <= head_q[31];
      end
      S_RED: begin
        if (!red_diff[vri_pkg::REM_W]) rem_q <= red_diff[vri_pkg::REM_W-1:0];
      end
      S_WRAP: z_q <= z_wrap;
      S_FOLD: begin
        // Fold into [-pi/2, pi/2]; the results are negated at the end
        cx_q <= vri_pkg::GAIN_Q30[vri_pkg::CS_W-1:0];
        cy_q <= '0;
        if (z_q > vri_pkg::HALF_PI_Q30) begin
          z_q    <= z_q - vri_pkg::PI_Q30;
          fneg_q <= 1'b1;
        end else if (z_q < -vri_pkg::HALF_PI_Q30) begin
          z_q    <= z_q + vri_pkg::PI_Q30;
          fneg_q <= 1'b1;
        end else begin
          fneg_q <= 1'b0;
        end
      end
      S_CORD: begin
        if (!z_q[vri_pkg::Z_W-1]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          z_q  <= z_q - atan_z;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          z_q  <= z_q + atan_z;
        end
      end
      S_CNEG: begin
        if (fneg_q) begin
          cx_q <= -cx_q;
          cy_q <= -cy_q;
        end
      end
      // Products are registered and arrive in the state after their operands
      S_MVS: dx_q <= prod_q[vri_pkg::DV_W-1:0];
      S_MWS: dy_q <= prod_q[vri_pkg::DV_W-1:0];
      S_MWC: dx_q <= dx_q - prod_q[vri_pkg::DV_W-1:0];
      S_XLO: dy_q <= dy_q + prod_q[vri_pkg::DV_W-1:0];
      S_XHI: plo_q <= prod_q[vri_pkg::PLO_W-1:0];
      S_YLO: inc_q <= vri_pkg::round_q42(prod_q, plo_q);
      S_YHI: plo_q <= prod_q[vri_pkg::PLO_W-1:0];
      S_YSUM: inc_q <= vri_pkg::round_q42(prod_q, plo_q);
      S_DONE: begin
        if (res_free) begin
          out_x_q    <= x_acc_q;
          out_y_q    <= y_new;
          out_head_q <= head_q;
        end
      end
      default: ;
    endcase
  end

  // A taken request blocks the next one until its pose is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_i.ready)
    else $error("request taken while a step is in progress");

  // The reduction leaves a residue below 2*pi
  a_reduce_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRAP) |-> (rem_q < vri_pkg::TWO_PI_REM))
    else $error("modulo reduction residue out of range");

  // The CORDIC counter never passes the configured iteration count
  a_cordic_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORD) |-> (iter_q <= IW'(CORDIC_STEPS - 1)))
    else $error("CORDIC iteration count overrun");

  // A pose is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && out_valid_q && !res_o.ready |=> (state_q == S_DONE))
    else $error("finished pose left while output still held");

endmodule

### bench/tb_velocity_rollout_integrator.sv
// Testbench for velocity_rollout_integrator: random and directed rollout steps,
// a pose predictor in a small scoreboard class, and random idling on the request and pose channels.
// Depends on vri_pkg, the channel interfaces in vri_ifs.sv and the block itself.
`timescale 1ns / 1ps

localparam int unsigned CORDIC_ITERS = vri_pkg::CORDIC_STEPS_DEF;
localparam int unsigned ARCTAN_LEN   = 24;

// Q2.30 angle constants and CORDIC start value
localparam longint CORDIC_X0   = 64'sd652032874;
localparam longint ANGLE_PI    = 64'sd3373259426;
localparam longint ANGLE_HALF  = 64'sd1686629713;
localparam longint ANGLE_TWO   = 64'sd6746518852;
localparam longint POSE_MAX    = 64'sd2147483647;
localparam longint POSE_MIN    = -64'sd2147483648;

typedef struct packed {
  logic signed [vri_pkg::SPEED_W-1:0] forward_speed;
  logic signed [vri_pkg::SPEED_W-1:0] lateral_speed;
  logic signed [vri_pkg::SPEED_W-1:0] turn_rate;
  logic                               rollout_start;
} step_req_t;

typedef struct packed {
  logic signed [vri_pkg::POSE_W-1:0] x;
  logic signed [vri_pkg::POSE_W-1:0] y;
  logic signed [vri_pkg::POSE_W-1:0] heading;
} pose_t;

// Dead-reckoning predictor plus the queue of poses still owed by the block
class pose_scoreboard;
  logic [vri_pkg::STEP_W-1:0]         step_time;
  logic signed [vri_pkg::POSE_W-1:0]  start_x;
  logic signed [vri_pkg::POSE_W-1:0]  start_y;
  logic signed [vri_pkg::HEAD0_W-1:0] start_heading;
  logic                               holonomic;
  longint                             heading_acc;
  longint                             x_acc;
  longint                             y_acc;
  longint                             arctan[ARCTAN_LEN];
  pose_t                              pose_q[$];
  int unsigned                        errors;

  function new();
    step_time     = vri_pkg::STEP_TIME_RST;
    start_x       = '0;
    start_y       = '0;
    start_heading = '0;
    holonomic     = 1'b0;
    heading_acc   = 0;
    x_acc         = 0;
    y_acc         = 0;
    errors        = 0;
    arctan = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
               16775850, 8388437, 4194282, 2097149, 1048575, 524287,
               262143, 131071, 65535, 32767, 16383, 8191,
               4095, 2047, 1023, 511, 255, 127};
  endfunction

  function void write_reg(logic [vri_pkg::CFG_IDX_W-1:0] idx,
                          logic [vri_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      vri_pkg::REG_STEP_TIME:     step_time = data[vri_pkg::STEP_W-1:0];
      vri_pkg::REG_START_X:       start_x = data;
      vri_pkg::REG_START_Y:       start_y = data;
      vri_pkg::REG_START_HEADING: start_heading = data[vri_pkg::HEAD0_W-1:0];
      vri_pkg::REG_HOLONOMIC:     holonomic = data[0];
      default: ;
    endcase
  endfunction

  // Round half up: add half an LSB, then arithmetic (floor) shift
  function longint round_shift(longint v, int unsigned sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function longint clamp_s32(longint v);
    if (v > POSE_MAX) return POSE_MAX;
    if (v < POSE_MIN) return POSE_MIN;
    return v;
  endfunction

  // Integrate one accepted step request and queue the pose it must produce
  function void note_step(step_req_t s);
    longint v, w, r, dt, z, cx, sy, xs, ys, dx, dy;
    bit     flip;
    pose_t  p;
    v  = longint'(s.forward_speed);
    w  = longint'(s.lateral_speed);
    r  = longint'(s.turn_rate);
    dt = longint'(step_time);
    if (s.rollout_start) begin
      heading_acc = longint'(start_heading);
      x_acc       = longint'(start_x);
      y_acc       = longint'(start_y);
    end
    heading_acc = clamp_s32(heading_acc + round_shift(r * dt, 12));

    // reduce to [-pi, pi] in Q2.30, then fold into [-pi/2, pi/2]
    z = (heading_acc * 16384) % ANGLE_TWO;
    if (z > ANGLE_PI) z -= ANGLE_TWO;
    if (z < -ANGLE_PI) z += ANGLE_TWO;
    flip = 1'b0;
    if (z > ANGLE_HALF) begin
      z -= ANGLE_PI;
      flip = 1'b1;
    end else if (z < -ANGLE_HALF) begin
      z += ANGLE_PI;
      flip = 1'b1;
    end

    // rotation-mode CORDIC
    cx = CORDIC_X0;
    sy = 0;
    for (int i = 0; i < CORDIC_ITERS && i < ARCTAN_LEN; i++) begin
      xs = cx >>> i;
      ys = sy >>> i;
      if (z >= 0) begin
        cx = cx - ys;
        sy = sy + xs;
        z  = z - arctan[i];
      end else begin
        cx = cx + ys;
        sy = sy - xs;
        z  = z + arctan[i];
      end
    end
    if (flip) begin
      cx = -cx;
      sy = -sy;
    end

    // body to world frame, lateral term only on a holonomic base
    dx = v * cx;
    dy = v * sy;
    if (holonomic) begin
      dx -= w * sy;
      dy += w * cx;
    end
    x_acc = clamp_s32(x_acc + round_shift(dx * dt, 42));
    y_acc = clamp_s32(y_acc + round_shift(dy * dt, 42));

    p.x       = x_acc[vri_pkg::POSE_W-1:0];
    p.y       = y_acc[vri_pkg::POSE_W-1:0];
    p.heading = heading_acc[vri_pkg::POSE_W-1:0];
    pose_q.push_back(p);
  endfunction

  function void check_pose(pose_t got);
    pose_t want;
    if (pose_q.size() == 0) begin
      $display("%0t: pose with no step pending: x=%0d y=%0d heading=%0d",
               $time, got.x, got.y, got.heading);
      errors++;
      return;
    end
    want = pose_q.pop_front();
    if (got.x !== want.x) begin
      $display("%0t: pose_x expected %0d, got %0d", $time, want.x, got.x);
      errors++;
    end
    if (got.y !== want.y) begin
      $display("%0t: pose_y expected %0d, got %0d", $time, want.y, got.y);
      errors++;
    end
    if (got.heading !== want.heading) begin
      $display("%0t: pose_heading expected %0d, got %0d", $time, want.heading, got.heading);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return pose_q.size();
  endfunction
endclass

module tb_velocity_rollout_integrator;

  localparam int unsigned IDX_W        = vri_pkg::CFG_IDX_W;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = CORDIC_ITERS + 40;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_STEPS  = 180;
  localparam int unsigned SPIN_STEPS   = 300;
  localparam int unsigned HOLD_CYCLES  = 600;

  localparam logic signed [vri_pkg::SPEED_W-1:0] SPD_MAX = 16'sh7FFF;
  localparam logic signed [vri_pkg::SPEED_W-1:0] SPD_MIN = 16'sh8000;
  localparam logic [vri_pkg::CFG_DATA_W-1:0] DT_MAX     = 32'h0000_FFFF;
  localparam logic [vri_pkg::CFG_DATA_W-1:0] HDG_PI     = 32'd205887;
  localparam logic [vri_pkg::CFG_DATA_W-1:0] HDG_HALF   = 32'd102944;
  localparam logic [vri_pkg::CFG_DATA_W-1:0] HDG_TOP    = 32'h0003_FFFF;  // most positive, beyond pi
  localparam logic [vri_pkg::CFG_DATA_W-1:0] HDG_BOTTOM = 32'h0004_0000;  // most negative, beyond -pi

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  vri_req_if req_if ();
  vri_res_if res_if ();
  vri_cfg_if cfg_if ();

  pose_scoreboard sb;
  int unsigned    hold_off_cycles = 0;
  int unsigned    cycle_count = 0;

  velocity_rollout_integrator #(
    .CORDIC_STEPS(CORDIC_ITERS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [vri_pkg::SPEED_W-1:0] rand_speed();
    logic signed [vri_pkg::SPEED_W-1:0] sp;
    case ($urandom_range(0, 19))
      0:       sp = SPD_MAX;
      1:       sp = SPD_MIN;
      2:       sp = '0;
      default: sp = 16'($urandom);
    endcase
    return sp;
  endfunction

  // All drive tasks start and end at a falling edge
  task automatic drive_step(logic signed [vri_pkg::SPEED_W-1:0] v,
                            logic signed [vri_pkg::SPEED_W-1:0] w,
                            logic signed [vri_pkg::SPEED_W-1:0] r, logic start);
    step_req_t s;
    s.forward_speed = v;
    s.lateral_speed = w;
    s.turn_rate     = r;
    s.rollout_start = start;
    req_if.valid         = 1'b1;
    req_if.forward_speed = v;
    req_if.lateral_speed = w;
    req_if.turn_rate     = r;
    req_if.rollout_start = start;
    do @(posedge clk); while (!req_if.ready);
    sb.note_step(s);
    @(negedge clk);
    req_if.valid = 1'b0;
    repeat (idle_len()) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [vri_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_regs(logic [vri_pkg::CFG_DATA_W-1:0] dt,
                          logic [vri_pkg::CFG_DATA_W-1:0] x0,
                          logic [vri_pkg::CFG_DATA_W-1:0] y0,
                          logic [vri_pkg::CFG_DATA_W-1:0] hdg0,
                          logic [vri_pkg::CFG_DATA_W-1:0] holo);
    write_reg(vri_pkg::REG_STEP_TIME, dt);
    write_reg(vri_pkg::REG_START_X, x0);
    write_reg(vri_pkg::REG_START_Y, y0);
    write_reg(vri_pkg::REG_START_HEADING, hdg0);
    write_reg(vri_pkg::REG_HOLONOMIC, holo);
  endtask

  // Sender pause: every owed pose has come back
  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [vri_pkg::CFG_DATA_W-1:0] rand_start_pos();
    logic [vri_pkg::CFG_DATA_W-1:0] p;
    case ($urandom_range(0, 9))
      0:       p = 32'h7FFF_0000 + $urandom_range(0, 65535);
      1:       p = 32'h8000_0000 + $urandom_range(0, 65535);
      2:       p = $urandom_range(0, 65535) - 32768;
      default: p = $urandom;
    endcase
    return p;
  endfunction

  // Pose sink: random back-pressure, plus the long hold-off on request
  initial begin
    int unsigned stall;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = (hold_off_cycles != 0) ? hold_off_cycles : idle_len();
      hold_off_cycles = 0;
      if (stall != 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready = 1'b1;
      do @(posedge clk); while (!res_if.valid);
      sb.check_pose('{x: res_if.pose_x, y: res_if.pose_y, heading: res_if.pose_heading});
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned run_len;
    logic [vri_pkg::CFG_DATA_W-1:0] dt;
    sb = new();
    req_if.valid         = 1'b0;
    req_if.forward_speed = '0;
    req_if.lateral_speed = '0;
    req_if.turn_rate     = '0;
    req_if.rollout_start = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset registers; the first step has no start mark and starts from the zero pose
    drive_step(16'sd4096, '0, '0, 1'b0);
    drive_step(SPD_MAX, SPD_MAX, SPD_MAX, 1'b0);
    drive_step(SPD_MIN, SPD_MIN, SPD_MIN, 1'b0);
    drive_step('0, '0, '0, 1'b1);
    drive_step(SPD_MIN, SPD_MAX, 16'sd1, 1'b0);

    // Longest step, pose next to the limits: x saturates high, y low, then recover
    wait_drained();
    set_regs(DT_MAX, 32'h7FFF_F000, 32'h8000_1000, '0, 32'd1);
    for (int k = int'(vri_pkg::REG_HOLONOMIC) + 1; k < (1 << IDX_W); k++) begin
      write_reg(IDX_W'(k), $urandom);
    end
    drive_step(SPD_MAX, SPD_MIN, '0, 1'b1);
    drive_step(SPD_MAX, SPD_MIN, '0, 1'b0);
    drive_step(SPD_MIN, SPD_MAX, '0, 1'b0);

    // Zero step time, start heading beyond pi, pose at the opposite limits
    wait_drained();
    set_regs('0, 32'h8000_0000, 32'h7FFF_FFFF, HDG_TOP, '0);
    drive_step(SPD_MAX, SPD_MAX, SPD_MAX, 1'b1);
    drive_step(SPD_MIN, SPD_MIN, SPD_MIN, 1'b0);

    // Start heading beyond -pi
    wait_drained();
    set_regs(DT_MAX, '0, '0, HDG_BOTTOM, 32'd1);
    drive_step(SPD_MAX, SPD_MAX, SPD_MIN, 1'b1);
    drive_step(16'sd4096, '0, SPD_MAX, 1'b0);

    // Headings on the fold boundaries
    wait_drained();
    write_reg(vri_pkg::REG_START_HEADING, HDG_HALF);
    drive_step(SPD_MAX, SPD_MAX, '0, 1'b1);
    wait_drained();
    write_reg(vri_pkg::REG_START_HEADING, -HDG_HALF);
    drive_step(SPD_MAX, SPD_MAX, '0, 1'b1);
    wait_drained();
    write_reg(vri_pkg::REG_START_HEADING, HDG_PI);
    drive_step(SPD_MAX, SPD_MAX, '0, 1'b1);
    wait_drained();
    write_reg(vri_pkg::REG_START_HEADING, -HDG_PI);
    drive_step(SPD_MAX, SPD_MAX, '0, 1'b1);

    // Random phases: fresh registers each, then rollouts of random length
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       dt = '0;
        1:       dt = DT_MAX;
        2:       dt = $urandom_range(0, 1023);
        default: dt = $urandom;
      endcase
      set_regs(dt, rand_start_pos(), rand_start_pos(), $urandom, $urandom);
      if ($urandom_range(0, 2) == 0) write_reg(IDX_W'($urandom_range(5, 7)), $urandom);

      // one phase opens with a burst into a stalled pose sink
      if (ph == 3) begin
        hold_off_cycles = HOLD_CYCLES;
        drive_step(rand_speed(), rand_speed(), rand_speed(), 1'b1);
        for (int k = 0; k < 11; k++) begin
          req_if.valid         = 1'b1;
          drive_step(rand_speed(), rand_speed(), rand_speed(), 1'b0);
        end
      end

      sent = 0;
      while (sent < PHASE_STEPS) begin
        run_len = $urandom_range(1, 40);
        // a rollout now and then lacks its start mark and continues the last pose
        drive_step(rand_speed(), rand_speed(), rand_speed(), $urandom_range(0, 19) != 0);
        for (int k = 1; k < run_len; k++) begin
          drive_step(rand_speed(), rand_speed(), rand_speed(), $urandom_range(0, 49) == 0);
        end
        sent += run_len;
      end
    end

    // Long spin at full rate: heading winds through many turns, then backs off
    wait_drained();
    set_regs(DT_MAX, rand_start_pos(), rand_start_pos(), HDG_PI, 32'd1);
    drive_step(rand_speed(), rand_speed(), SPD_MAX, 1'b1);
    for (int k = 1; k < SPIN_STEPS; k++) begin
      drive_step(rand_speed(), rand_speed(), 16'(SPD_MAX - $urandom_range(0, 200)), 1'b0);
    end
    for (int k = 0; k < 40; k++) begin
      drive_step(rand_speed(), rand_speed(), 16'(SPD_MIN + $urandom_range(0, 200)), 1'b0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
